// ===== hw/rtl/ddo_pkg.sv =====
package ddo_pkg;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned CRD_W  = 33;

  localparam logic [GAIN_W-1:0]      TURN_GAIN_RESET  = 16'd19661;
  localparam logic signed [CRD_W-1:0] CORDIC_START    = 33'sd652032874;
  localparam logic [29:0]            TURNS_PER_RADIAN = 30'd683565276;
  localparam logic signed [31:0]     QUARTER_TURN     = 32'sd1073741824;
  localparam logic signed [65:0]     ROUND_HALF       = 66'sd134217728;

  // binary-angle arctangent of 2^-i
  localparam logic [29:0] ATAN_LUT [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_APPLY,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    OP_COS,
    OP_SIN,
    OP_GAIN,
    OP_TURN
  } op_e;

endpackage

// ===== hw/rtl/ddo_in_if.sv =====
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_position;
  logic signed [31:0] right_position;

  modport source (output valid, output left_position, output right_position, input ready);
  modport sink (input valid, input left_position, input right_position, output ready);
endinterface

// ===== hw/rtl/ddo_out_if.sv =====
interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] heading;
  logic               first_sample;
  logic               saturated;

  modport source (
    output valid, output pose_x, output pose_y, output heading,
    output first_sample, output saturated, input ready
  );
  modport sink (
    input valid, input pose_x, input pose_y, input heading,
    input first_sample, input saturated, output ready
  );
endinterface

// ===== hw/rtl/diff_drive_odometry.sv =====
// Steps per sample: CORDIC loop, then multiply-accumulate for cos, sin, gain and
// turn, then the output register; the first sample after reset goes straight to it.
// One sample at a time: a new sample is taken only in idle, after the CORDIC loop and
// ten passes of the shared 35x17 multiply-accumulate unit for the previous one.
// Reset: pose, heading and previous wheel angles clear, turn_gain returns to 0.3.
module diff_drive_odometry #(
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ddo_pkg::GAIN_W-1:0]  cfg_wdata_i,
  ddo_in_if.sink                      sample_i,
  ddo_out_if.source                   pose_o
);
  import ddo_pkg::*;

  localparam int unsigned CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

  state_e state_q, state_d;
  op_e    op_q;

  logic [GAIN_W-1:0]         gain_q;
  logic [POS_W-1:0]          prev_l_q, prev_r_q;
  logic                      have_prev_q;
  logic [POS_W-1:0]          acc_x_q, acc_y_q, head_q;
  logic signed [33:0]        sum_q, diff_q;
  logic signed [CRD_W-1:0]   cx_q, cy_q, cz_q;
  logic                      flip_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [1:0]                chunk_q;
  logic signed [65:0]        mac_q;
  logic signed [49:0]        p_q;
  logic                      first_q, sat_q;

  logic                      out_valid_q;
  logic [POS_W-1:0]          out_x_q, out_y_q, out_h_q;
  logic                      out_first_q, out_sat_q;
  logic                      out_load;

  // wheel deltas
  logic signed [32:0] dl, dr;
  logic signed [33:0] sum_w, diff_w;
  always_comb begin
    dl     = $signed({sample_i.left_position[31], sample_i.left_position})
           - $signed({prev_l_q[31], prev_l_q});
    dr     = $signed({sample_i.right_position[31], sample_i.right_position})
           - $signed({prev_r_q[31], prev_r_q});
    sum_w  = $signed({dl[32], dl}) + $signed({dr[32], dr});
    diff_w = $signed({dl[32], dl}) - $signed({dr[32], dr});
  end

  // fold heading into [-pi/2, pi/2]
  logic              fold;
  logic [31:0]       angle;
  always_comb begin
    fold  = ($signed(head_q) > QUARTER_TURN) || ($signed(head_q) < -QUARTER_TURN);
    angle = fold ? {~head_q[31], head_q[30:0]} : head_q;
  end

  // CORDIC rotation step
  logic signed [CRD_W-1:0] x_sh, y_sh, atan_v, nx, ny, nz;
  always_comb begin
    x_sh   = cx_q >>> cnt_q;
    y_sh   = cy_q >>> cnt_q;
    atan_v = $signed({3'b000, ATAN_LUT[5'(cnt_q)]});
    if (!cz_q[CRD_W-1]) begin
      nx = cx_q - y_sh;
      ny = cy_q + x_sh;
      nz = cz_q - atan_v;
    end else begin
      nx = cx_q + y_sh;
      ny = cy_q - x_sh;
      nz = cz_q + atan_v;
    end
  end

  // shared multiply-accumulate, one 16-bit chunk of b_op per cycle
  logic signed [CRD_W-1:0] cos_v, sin_v;
  logic signed [34:0]      a_op;
  logic [63:0]             b_op;
  logic [1:0]              chunk_last;
  logic [15:0]             b_chunk;
  logic signed [16:0]      b17;
  logic signed [51:0]      pp;
  logic signed [65:0]      pp_sh, mac_d;
  always_comb begin
    cos_v = (flip_q ? -cx_q : cx_q) >>> 2;
    sin_v = (flip_q ? -cy_q : cy_q) >>> 2;
    case (op_q)
      OP_COS: begin
        a_op = $signed({sum_q[33], sum_q});
        b_op = {{31{cos_v[CRD_W-1]}}, cos_v};
      end
      OP_SIN: begin
        a_op = $signed({sum_q[33], sum_q});
        b_op = {{31{sin_v[CRD_W-1]}}, sin_v};
      end
      OP_GAIN: begin
        a_op = $signed({diff_q[33], diff_q});
        b_op = {48'd0, gain_q};
      end
      OP_TURN: begin
        a_op = $signed({5'd0, TURNS_PER_RADIAN});
        b_op = {{14{p_q[49]}}, p_q};
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
    chunk_last = (op_q == OP_TURN) ? 2'd3 : 2'd1;
    b_chunk    = b_op[{chunk_q, 4'b0000} +: 16];
    // top chunk carries the sign
    b17        = (chunk_q == chunk_last) ? $signed({b_chunk[15], b_chunk})
                                         : $signed({1'b0, b_chunk});
    pp         = a_op * b17;
    pp_sh      = $signed({{14{pp[51]}}, pp}) <<< {chunk_q, 4'b0000};
    mac_d      = (chunk_q == 2'd0) ? pp_sh : mac_q + pp_sh;
  end

  // round to Q16.16, add to x or y and clamp
  logic signed [65:0] rnd;
  logic signed [35:0] dpos;
  logic [POS_W-1:0]   target, clamped;
  logic signed [36:0] tsum;
  logic               ovf;
  always_comb begin
    rnd    = mac_q + ROUND_HALF;
    dpos   = rnd[63:28];
    target = (op_q == OP_COS) ? acc_x_q : acc_y_q;
    tsum   = $signed({{5{target[31]}}, target}) + $signed({dpos[35], dpos});
    ovf    = !((&tsum[36:31]) || !(|tsum[36:31]));
    if (ovf) begin
      clamped = tsum[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      clamped = tsum[31:0];
    end
  end

  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || pose_o.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          state_d = have_prev_q ? ST_CORDIC : ST_FINISH;
        end
      end
      ST_CORDIC: begin
        if (cnt_q == CNT_LAST) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (chunk_q == chunk_last) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_d = (op_q == OP_TURN) ? ST_FINISH : ST_MUL;
      end
      ST_FINISH: begin
        if (!out_valid_q || pose_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= TURN_GAIN_RESET;
      have_prev_q <= 1'b0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      head_q      <= '0;
      op_q        <= OP_COS;
      cnt_q       <= '0;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pose_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (sample_i.valid) begin
            sum_q       <= sum_w;
            diff_q      <= diff_w;
            prev_l_q    <= sample_i.left_position;
            prev_r_q    <= sample_i.right_position;
            have_prev_q <= 1'b1;
            first_q     <= !have_prev_q;
            sat_q       <= 1'b0;
            cx_q        <= CORDIC_START;
            cy_q        <= '0;
            cz_q        <= $signed({angle[31], angle});
            flip_q      <= fold;
            cnt_q       <= '0;
            op_q        <= OP_COS;
            chunk_q     <= '0;
          end
        end
        ST_CORDIC: begin
          cx_q  <= nx;
          cy_q  <= ny;
          cz_q  <= nz;
          cnt_q <= cnt_q + 1'b1;
        end
        ST_MUL: begin
          mac_q   <= mac_d;
          chunk_q <= chunk_q + 2'd1;
        end
        ST_APPLY: begin
          chunk_q <= '0;
          case (op_q)
            OP_COS: begin
              acc_x_q <= clamped;
              sat_q   <= sat_q | ovf;
              op_q    <= OP_SIN;
            end
            OP_SIN: begin
              acc_y_q <= clamped;
              sat_q   <= sat_q | ovf;
              op_q    <= OP_GAIN;
            end
            OP_GAIN: begin
              p_q  <= mac_q[49:0];
              op_q <= OP_TURN;
            end
            OP_TURN: begin
              head_q <= head_q + mac_q[63:32];
            end
            default: ;
          endcase
        end
        ST_FINISH: begin
          if (out_load) begin
            out_x_q     <= acc_x_q;
            out_y_q     <= acc_y_q;
            out_h_q     <= head_q;
            out_first_q <= first_q;
            out_sat_q   <= sat_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign sample_i.ready      = (state_q == ST_IDLE);
  assign pose_o.valid        = out_valid_q;
  assign pose_o.pose_x       = $signed(out_x_q);
  assign pose_o.pose_y       = $signed(out_y_q);
  assign pose_o.heading      = $signed(out_h_q);
  assign pose_o.first_sample = out_first_q;
  assign pose_o.saturated    = out_sat_q;

endmodule
